/* rtl/core/edr_pkg.sv */
// ----------------------------------------------------------------------------
// edr_pkg: shared types and constants for the edit-distance row stack
// Row geometry, cell and address widths, item and register codes.
// ----------------------------------------------------------------------------
package edr_pkg;

	localparam int MAX_BASE_LEN = 16;
	localparam int MAX_DEPTH    = 32;
	localparam int ROW_CELLS    = MAX_BASE_LEN + 1;
	localparam int MEM_DEPTH    = MAX_DEPTH * ROW_CELLS;
	localparam int CELL_W       = 6;
	localparam int ADDR_W       = $clog2(MEM_DEPTH);
	localparam int COUNT_W      = $clog2(MAX_DEPTH + 1);
	localparam int ROW_W        = $clog2(MAX_DEPTH);
	localparam int COL_W        = $clog2(ROW_CELLS);
	localparam int LEN_W        = 5;

	typedef enum logic [1:0] {
		KIND_APPEND = 2'd0,
		KIND_POP    = 2'd1,
		KIND_CLEAR  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		REG_BASE_LENGTH = 2'd0,
		REG_CHARS_LOW   = 2'd1,
		REG_CHARS_HIGH  = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic [CELL_W-1:0] tail;
		logic [CELL_W-1:0] best;
	} row_sum_t;

	// Row-major cell address: row * ROW_CELLS + column.
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		logic [ADDR_W+COL_W-1:0] prod;
		prod = (ADDR_W+COL_W)'(row) * (ADDR_W+COL_W)'(ROW_CELLS);
		return prod[ADDR_W-1:0] + ADDR_W'(col);
	endfunction

endpackage

/* rtl/core/edr_row_mem.sv */
// ----------------------------------------------------------------------------
// edr_row_mem: row store
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module edr_row_mem (
	input  logic                         clk,
	input  edr_pkg::mem_wr_t             wr,
	input  logic [edr_pkg::ADDR_W-1:0]   raddr,
	output logic [edr_pkg::CELL_W-1:0]   rdata
);

	logic [edr_pkg::CELL_W-1:0] mem_q [edr_pkg::MEM_DEPTH];
	logic [edr_pkg::CELL_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/edr_cell_unit.sv */
// ----------------------------------------------------------------------------
// edr_cell_unit: one dynamic-programming cell
// min(diagonal + substitution cost, above + 1, left + 1).
// ----------------------------------------------------------------------------
module edr_cell_unit (
	input  logic [edr_pkg::CELL_W-1:0] diag,
	input  logic [edr_pkg::CELL_W-1:0] up,
	input  logic [edr_pkg::CELL_W-1:0] left,
	input  logic                       match,
	output logic [edr_pkg::CELL_W-1:0] cell_min
);

	logic [edr_pkg::CELL_W-1:0] sub_c;
	logic [edr_pkg::CELL_W-1:0] del_c;
	logic [edr_pkg::CELL_W-1:0] ins_c;
	logic [edr_pkg::CELL_W-1:0] m1;

	// cells never exceed MAX_DEPTH, so +1 cannot wrap
	assign sub_c    = diag + (match ? '0 : edr_pkg::CELL_W'(1));
	assign del_c    = up + edr_pkg::CELL_W'(1);
	assign ins_c    = left + edr_pkg::CELL_W'(1);
	assign m1       = (del_c < sub_c) ? del_c : sub_c;
	assign cell_min = (ins_c < m1) ? ins_c : m1;

endmodule

/* rtl/core/incremental_edit_distance_row_stack.sv */
// ----------------------------------------------------------------------------
// incremental_edit_distance_row_stack: Levenshtein row stack against a base word
//
// Channel   Direction  Handshake                  Payload
// item      in         start & !busy              kind, symbol
// result    out        done (one cycle, no stall) distance, best_reachable,
//                                                 depth, ignored
// config    in         APB write (psel/penable)   base_length, base_chars_*
//
// Append: busy from the accepting edge until the last of the L cells (L =
// effective base length), one cell per cycle through the shared cell unit fed
// by the row store read port; done follows in the cycle after the last cell.
// Pop, clear and ignored items: done the cycle after the transfer, no busy.
// Reset leaves the stack empty; row store contents are not cleared.
// The receiver cannot stall; done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module incremental_edit_distance_row_stack (
	input  logic        clk,
	input  logic        arst_n,
	// item
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  symbol,
	// result
	output logic        done,
	output logic [5:0]  distance,
	output logic [5:0]  best_reachable,
	output logic [5:0]  depth,
	output logic        ignored,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	localparam int CW = edr_pkg::CELL_W;
	localparam int RW = edr_pkg::ROW_W;
	localparam int JW = edr_pkg::COL_W;
	localparam int NW = edr_pkg::COUNT_W;

	typedef enum logic {ST_IDLE, ST_ROW} state_t;

	state_t                       state_q;
	logic [NW-1:0]                count_q;
	logic [edr_pkg::LEN_W-1:0]    base_length_q;
	logic [63:0]                  chars_low_q;
	logic [63:0]                  chars_high_q;
	logic [JW-1:0]                j_q;
	logic [7:0]                   sym_q;
	logic [CW-1:0]                diag_q;
	logic [CW-1:0]                left_q;
	logic [CW-1:0]                min_q;
	logic [CW-1:0]                top_dist_q;
	logic [CW-1:0]                top_best_q;
	edr_pkg::row_sum_t            summ_q [edr_pkg::MAX_DEPTH];
	logic                         done_q;
	logic [5:0]                   distance_q;
	logic [5:0]                   best_q;
	logic [5:0]                   depth_q;
	logic                         ignored_q;

	logic                         cfg_wr;
	edr_pkg::reg_idx_t            cfg_idx;
	logic [edr_pkg::LEN_W-1:0]    eff_len;
	logic [JW-1:0]                len_col;
	logic [127:0]                 base_chars;
	logic [3:0]                   char_idx;
	logic [7:0]                   base_ch;
	logic [CW-1:0]                up;
	logic [CW-1:0]                cell_min;
	logic [CW-1:0]                fin_best;
	logic [RW-1:0]                new_row;
	logic [RW-1:0]                prev_row;
	logic [RW-1:0]                pop_row;
	logic [CW-1:0]                r_val;
	logic [CW-1:0]                cur_dist;
	logic [CW-1:0]                cur_best;
	logic                         accept;
	edr_pkg::mem_wr_t             mem_wr;
	logic [edr_pkg::ADDR_W-1:0]   mem_raddr;
	logic [CW-1:0]                mem_rdata;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = edr_pkg::reg_idx_t'(paddr[4:3]);

	always_comb begin
		case (cfg_idx)
			edr_pkg::REG_BASE_LENGTH: prdata = 64'(base_length_q);
			edr_pkg::REG_CHARS_LOW:   prdata = chars_low_q;
			edr_pkg::REG_CHARS_HIGH:  prdata = chars_high_q;
			default:                  prdata = '0;
		endcase
	end

	assign eff_len    = (base_length_q > edr_pkg::LEN_W'(edr_pkg::MAX_BASE_LEN)) ?
	                    edr_pkg::LEN_W'(edr_pkg::MAX_BASE_LEN) : base_length_q;
	assign len_col    = JW'(eff_len);
	assign base_chars = {chars_high_q, chars_low_q};
	assign char_idx   = 4'(j_q - JW'(1));
	assign base_ch    = base_chars[{char_idx, 3'b000} +: 8];

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & ~busy;

	assign new_row  = count_q[RW-1:0];
	assign prev_row = count_q[RW-1:0] - RW'(1);
	assign pop_row  = count_q[RW-1:0] - RW'(2);
	assign r_val    = CW'(count_q) + CW'(1);

	// row 0 is implicit: cell j holds j
	assign up = (count_q == '0) ? CW'(j_q) : mem_rdata;

	edr_cell_unit u_cell (
		.diag     (diag_q),
		.up       (up),
		.left     (left_q),
		.match    (base_ch == sym_q),
		.cell_min (cell_min)
	);

	assign fin_best = (cell_min < min_q) ? cell_min : min_q;

	// summary of the current top row
	assign cur_dist = (count_q == '0) ? CW'(eff_len) : top_dist_q;
	assign cur_best = (count_q == '0) ? '0 : top_best_q;

	always_comb begin
		mem_wr    = '0;
		mem_raddr = edr_pkg::cell_addr(prev_row, JW'(1));
		if (state_q == ST_ROW) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = edr_pkg::cell_addr(new_row, j_q);
			mem_wr.data = cell_min;
			mem_raddr   = edr_pkg::cell_addr(prev_row, j_q + JW'(1));
		end else if (accept && edr_pkg::kind_t'(kind) == edr_pkg::KIND_APPEND &&
				count_q < NW'(edr_pkg::MAX_DEPTH)) begin
			mem_wr.en   = 1'b1;
			mem_wr.addr = edr_pkg::cell_addr(new_row, '0);
			mem_wr.data = r_val;
		end
	end

	edr_row_mem u_mem (
		.clk   (clk),
		.wr    (mem_wr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// row summaries, one per stored row
	always_ff @(posedge clk) begin
		if (state_q == ST_ROW && j_q == len_col) begin
			summ_q[new_row] <= '{tail: cell_min, best: fin_best};
		end else if (accept && edr_pkg::kind_t'(kind) == edr_pkg::KIND_APPEND &&
				count_q < NW'(edr_pkg::MAX_DEPTH) && eff_len == '0) begin
			summ_q[new_row] <= '{tail: r_val, best: r_val};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			base_length_q <= '0;
			chars_low_q   <= '0;
			chars_high_q  <= '0;
			done_q        <= 1'b0;
			j_q           <= '0;
			sym_q         <= '0;
			diag_q        <= '0;
			left_q        <= '0;
			min_q         <= '0;
			top_dist_q    <= '0;
			top_best_q    <= '0;
			distance_q    <= '0;
			best_q        <= '0;
			depth_q       <= '0;
			ignored_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_wr) begin
				case (cfg_idx)
					edr_pkg::REG_BASE_LENGTH: begin
						base_length_q <= pwdata[edr_pkg::LEN_W-1:0];
						count_q       <= '0;
					end
					edr_pkg::REG_CHARS_LOW: begin
						chars_low_q <= pwdata;
						count_q     <= '0;
					end
					edr_pkg::REG_CHARS_HIGH: begin
						chars_high_q <= pwdata;
						count_q      <= '0;
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sym_q <= symbol;
						case (edr_pkg::kind_t'(kind))
							edr_pkg::KIND_APPEND: begin
								if (count_q < NW'(edr_pkg::MAX_DEPTH)) begin
									if (eff_len == '0) begin
										count_q    <= count_q + NW'(1);
										top_dist_q <= r_val;
										top_best_q <= r_val;
										done_q     <= 1'b1;
										distance_q <= r_val;
										best_q     <= r_val;
										depth_q    <= 6'(count_q + NW'(1));
										ignored_q  <= 1'b0;
									end else begin
										state_q <= ST_ROW;
										j_q     <= JW'(1);
										diag_q  <= CW'(count_q);
										left_q  <= r_val;
										min_q   <= r_val;
									end
								end else begin
									done_q     <= 1'b1;
									distance_q <= cur_dist;
									best_q     <= cur_best;
									depth_q    <= 6'(count_q);
									ignored_q  <= 1'b1;
								end
							end
							edr_pkg::KIND_POP: begin
								done_q <= 1'b1;
								if (count_q == '0) begin
									distance_q <= cur_dist;
									best_q     <= cur_best;
									depth_q    <= '0;
									ignored_q  <= 1'b1;
								end else begin
									count_q   <= count_q - NW'(1);
									depth_q   <= 6'(count_q - NW'(1));
									ignored_q <= 1'b0;
									if (count_q == NW'(1)) begin
										distance_q <= CW'(eff_len);
										best_q     <= '0;
									end else begin
										top_dist_q <= summ_q[pop_row].tail;
										top_best_q <= summ_q[pop_row].best;
										distance_q <= summ_q[pop_row].tail;
										best_q     <= summ_q[pop_row].best;
									end
								end
							end
							edr_pkg::KIND_CLEAR: begin
								done_q     <= 1'b1;
								count_q    <= '0;
								distance_q <= CW'(eff_len);
								best_q     <= '0;
								depth_q    <= '0;
								ignored_q  <= (count_q == '0);
							end
							default: begin
								done_q     <= 1'b1;
								distance_q <= cur_dist;
								best_q     <= cur_best;
								depth_q    <= 6'(count_q);
								ignored_q  <= 1'b1;
							end
						endcase
					end
				end
				ST_ROW: begin
					diag_q <= up;
					left_q <= cell_min;
					min_q  <= fin_best;
					j_q    <= j_q + JW'(1);
					if (j_q == len_col) begin
						state_q    <= ST_IDLE;
						count_q    <= count_q + NW'(1);
						top_dist_q <= cell_min;
						top_best_q <= fin_best;
						done_q     <= 1'b1;
						distance_q <= cell_min;
						best_q     <= fin_best;
						depth_q    <= 6'(count_q + NW'(1));
						ignored_q  <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done           = done_q;
	assign distance       = distance_q;
	assign best_reachable = best_q;
	assign depth          = depth_q;
	assign ignored        = ignored_q;

endmodule
